>>> sv/tecg_pkg.sv
// Shared types, codes and constants for the timer event coalescing group.
// No dependencies; imported by every module of the block but tecg_ram.
package tecg_pkg;

    localparam int TIME_W      = 32;
    localparam int SLACK_W     = 20;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int SLOT_IDX_W  = 4;
    localparam int OVERLAP_W   = 16;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    localparam int SLOTS_DEFAULT = 16;

    localparam logic [OVERLAP_W-1:0] MIN_OVERLAP_RESET = 16'd5;

    // commands
    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PROBE  = 2'd2;

    // result status
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_OVERLAP = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL       = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_LIVE   = 2'd3;

    // register word index (paddr[2])
    localparam logic REG_MIN_OVERLAP = 1'b0;

    typedef struct packed {
        logic [CMD_W-1:0]      cmd;
        logic [TIME_W-1:0]     start_time;
        logic [SLACK_W-1:0]    slack;
        logic [SLOT_IDX_W-1:0] slot_index;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [SLOT_IDX_W-1:0] slot_used;
        logic [TIME_W-1:0]     range_start;
        logic [TIME_W-1:0]     range_end;
        logic                  range_empty;
        logic                  holdable;
    } result_t;

    // window evaluation, handed from the window unit to the sequencer
    typedef struct packed {
        logic              add_ok;
        logic [TIME_W-1:0] new_start;
        logic [TIME_W-1:0] new_end;
        logic              holdable;
    } win_t;

endpackage

>>> sv/tecg_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module tecg_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/tecg_cfg.sv
// APB register file: holds min_overlap.
// Depends on tecg_pkg.
module tecg_cfg
    import tecg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [OVERLAP_W-1:0]  min_overlap
);

    logic [OVERLAP_W-1:0] min_overlap_reg;
    logic                 wr_en;

    assign pready      = 1'b1;
    assign wr_en       = psel && penable && pwrite && pready;
    assign min_overlap = min_overlap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_overlap_reg <= MIN_OVERLAP_RESET;
        end
        else if (wr_en && (paddr[2] == REG_MIN_OVERLAP))
        begin
            min_overlap_reg <= pwdata[OVERLAP_W-1:0];
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_MIN_OVERLAP: prdata = APB_DATA_W'(min_overlap_reg);
            default:         prdata = '0;
        endcase
    end

endmodule

>>> sv/tecg_window.sv
// Window unit: intersection check for add, overlap check for probe.
// Depends on tecg_pkg.
module tecg_window
    import tecg_pkg::*;
(
    input  logic [TIME_W-1:0]    start_time,
    input  logic [TIME_W-1:0]    end_time,
    input  logic [TIME_W-1:0]    window_start,
    input  logic [TIME_W-1:0]    window_end,
    input  logic [OVERLAP_W-1:0] min_overlap,
    input  logic                 group_empty,
    output win_t                 win
);

    logic [TIME_W-1:0] clip_start;
    logic [TIME_W-1:0] clip_end;
    logic [TIME_W-1:0] probe_hi;
    logic [TIME_W-1:0] probe_lo;
    logic              overlaps;

    assign overlaps   = (end_time > window_start) && (start_time < window_end);
    assign clip_start = (start_time <= window_start) ? window_start : start_time;
    assign clip_end   = (end_time >= window_end) ? window_end : end_time;

    // probe width: end - wstart when starting at or before the window,
    // else end - start if inside, else wend - start
    always_comb
    begin
        if (start_time <= window_start)
        begin
            probe_hi = end_time;
            probe_lo = window_start;
        end
        else if (end_time <= window_end)
        begin
            probe_hi = end_time;
            probe_lo = start_time;
        end
        else
        begin
            probe_hi = window_end;
            probe_lo = start_time;
        end
    end

    always_comb
    begin
        if (group_empty)
        begin
            win.add_ok    = 1'b1;
            win.new_start = start_time;
            win.new_end   = end_time;
        end
        else
        begin
            win.add_ok    = overlaps &&
                            ((clip_end - clip_start) > TIME_W'(min_overlap));
            win.new_start = clip_start;
            win.new_end   = clip_end;
        end
        win.holdable = overlaps && ((probe_hi - probe_lo) > TIME_W'(min_overlap));
    end

endmodule

>>> sv/timer_event_coalescing_group.sv
// Timer event coalescing group. Add: the sequencer decides, then, when holes exist,
// scans the live bits for the lowest dead slot, then hands the result on. Delete:
// decides, then walks the slot RAM read port one entry per cycle to intersect the
// remaining live slots. Probe, unknown commands, rejected adds, dead-slot deletes:
// decide, then finish. One item at a time. Reset clears live bits, counters and
// window; slot RAM is not cleared.
module timer_event_coalescing_group
    import tecg_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // item channel
    input  logic                  item_valid,
    output logic                  item_stall,
    input  item_t                 item,
    // result channel
    output logic                  result_valid,
    input  logic                  result_stall,
    output result_t               result,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // IW indexes a slot, CW counts up to SLOTS inclusive
    localparam int IW    = $clog2(SLOTS);
    localparam int CW    = $clog2(SLOTS + 1);
    localparam int RAM_W = 2 * TIME_W;
    localparam logic [CW-1:0] SLOTS_CNT = CW'(SLOTS);

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;  // evaluate command against state
    localparam logic [2:0] S_SEARCH = 3'd2;  // add: walk live bits for a hole
    localparam logic [2:0] S_SCAN   = 3'd3;  // delete: walk RAM, intersect
    localparam logic [2:0] S_FINISH = 3'd4;  // hand result to output register

    logic [2:0] state_reg, state_next;

    // latched item
    logic [CMD_W-1:0]      cmd_reg;
    logic [TIME_W-1:0]     s_reg;
    logic [TIME_W-1:0]     e_reg;
    logic [SLOT_IDX_W-1:0] idx_reg;

    // group state
    logic [SLOTS-1:0]  live_reg, live_next;
    logic [CW-1:0]     used_reg, used_next;
    logic [CW-1:0]     hole_reg, hole_next;
    logic [TIME_W-1:0] wstart_reg, wstart_next;
    logic [TIME_W-1:0] wend_reg, wend_next;

    // working registers
    logic [TIME_W-1:0] ns_reg, ns_next;
    logic [TIME_W-1:0] ne_reg, ne_next;
    logic [CW-1:0]     scan_reg, scan_next;
    logic              pend_valid_reg, pend_valid_next;
    logic              pend_live_reg, pend_live_next;
    logic              acc_any_reg, acc_any_next;
    logic [TIME_W-1:0] acc_a_reg, acc_a_next;
    logic [TIME_W-1:0] acc_b_reg, acc_b_next;
    result_t           res_reg, res_next;

    // output register
    logic    out_valid_reg, out_valid_next;
    result_t out_reg, out_next;

    // item transfer and saturating end
    logic              item_xfer;
    logic [TIME_W:0]   end_sum;
    logic [TIME_W-1:0] end_sat;

    // commit of an accepted add
    logic              commit_en;
    logic [IW-1:0]     commit_slot;
    logic              commit_reuse;
    logic [TIME_W-1:0] commit_ns;
    logic [TIME_W-1:0] commit_ne;

    logic              idx_in_range;
    logic [IW-1:0]     idx_slot;
    logic [IW-1:0]     scan_slot;

    // RAM: {start, end} per slot. Writes only on add commit, read data is used only in
    // the delete scan; items run one at a time so they never overlap.
    logic              ram_we;
    logic [RAM_W-1:0]  ram_rdata;
    logic [TIME_W-1:0] rd_start;
    logic [TIME_W-1:0] rd_end;

    logic [OVERLAP_W-1:0] min_overlap;
    win_t                 win;

    assign item_stall   = (state_reg != S_IDLE);
    assign item_xfer    = item_valid && !item_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    assign end_sum = {1'b0, item.start_time} + (TIME_W + 1)'(item.slack);
    assign end_sat = end_sum[TIME_W] ? '1 : end_sum[TIME_W-1:0];

    assign idx_in_range = (32'(idx_reg) < SLOTS);
    assign idx_slot     = IW'(idx_reg);
    assign scan_slot    = scan_reg[IW-1:0];
    assign rd_start     = ram_rdata[RAM_W-1:TIME_W];
    assign rd_end       = ram_rdata[TIME_W-1:0];

    tecg_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .min_overlap (min_overlap)
    );

    tecg_window u_window (
        .start_time   (s_reg),
        .end_time     (e_reg),
        .window_start (wstart_reg),
        .window_end   (wend_reg),
        .min_overlap  (min_overlap),
        .group_empty  (used_reg == hole_reg),
        .win          (win)
    );

    tecg_ram #(
        .WIDTH (RAM_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (commit_slot),
        .wdata ({s_reg, e_reg}),
        .raddr (scan_slot),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        live_next       = live_reg;
        used_next       = used_reg;
        hole_next       = hole_reg;
        wstart_next     = wstart_reg;
        wend_next       = wend_reg;
        ns_next         = ns_reg;
        ne_next         = ne_reg;
        scan_next       = scan_reg;
        pend_valid_next = pend_valid_reg;
        pend_live_next  = pend_live_reg;
        acc_any_next    = acc_any_reg;
        acc_a_next      = acc_a_reg;
        acc_b_next      = acc_b_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;

        commit_en    = 1'b0;
        commit_slot  = used_reg[IW-1:0];
        commit_reuse = 1'b0;
        commit_ns    = ns_reg;
        commit_ne    = ne_reg;
        ram_we       = 1'b0;

        // default result: current group window
        if (state_reg == S_DECIDE || state_reg == S_SEARCH)
        begin
            res_next.status      = ST_OK;
            res_next.slot_used   = '0;
            res_next.range_start = wstart_reg;
            res_next.range_end   = wend_reg;
            res_next.range_empty = 1'b0;
            res_next.holdable    = 1'b0;
        end

        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_xfer)
                begin
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                state_next = S_FINISH;
                unique case (cmd_reg)
                    CMD_ADD:
                    begin
                        commit_ns = win.new_start;
                        commit_ne = win.new_end;
                        if (!win.add_ok)
                        begin
                            res_next.status = ST_NO_OVERLAP;
                        end
                        else if (hole_reg != '0)
                        begin
                            ns_next    = win.new_start;
                            ne_next    = win.new_end;
                            scan_next  = '0;
                            state_next = S_SEARCH;
                        end
                        else if (used_reg >= SLOTS_CNT)
                        begin
                            res_next.status = ST_FULL;
                        end
                        else
                        begin
                            commit_en = 1'b1;
                        end
                    end

                    CMD_DELETE:
                    begin
                        if (!idx_in_range || !live_reg[idx_slot])
                        begin
                            res_next.status = ST_NOT_LIVE;
                        end
                        else
                        begin
                            live_next[idx_slot] = 1'b0;
                            // freeing the top slot shrinks the table,
                            // anything else leaves a hole
                            if ((CW'(idx_slot) + CW'(1)) != used_reg)
                            begin
                                hole_next = hole_reg + CW'(1);
                            end
                            else
                            begin
                                used_next = used_reg - CW'(1);
                            end
                            scan_next       = '0;
                            pend_valid_next = 1'b0;
                            acc_any_next    = 1'b0;
                            state_next      = S_SCAN;
                        end
                    end

                    CMD_PROBE:
                    begin
                        res_next.holdable = win.holdable;
                    end

                    default:
                    begin
                        res_next.status = ST_OK;
                    end
                endcase
            end

            S_SEARCH:
            begin
                if (scan_reg < used_reg)
                begin
                    if (!live_reg[scan_slot])
                    begin
                        commit_en    = 1'b1;
                        commit_slot  = scan_slot;
                        commit_reuse = 1'b1;
                    end
                    else
                    begin
                        scan_next = scan_reg + CW'(1);
                    end
                end
                else if (used_reg >= SLOTS_CNT)
                begin
                    res_next.status = ST_FULL;
                    state_next      = S_FINISH;
                end
                else
                begin
                    commit_en = 1'b1;
                end
            end

            S_SCAN:
            begin
                // data for the slot issued last cycle arrives now
                if (pend_valid_reg && pend_live_reg)
                begin
                    acc_any_next = 1'b1;
                    if (!acc_any_reg)
                    begin
                        acc_a_next = rd_start;
                        acc_b_next = rd_end;
                    end
                    else
                    begin
                        acc_a_next = (acc_a_reg < rd_start) ? rd_start : acc_a_reg;
                        acc_b_next = (acc_b_reg > rd_end) ? rd_end : acc_b_reg;
                    end
                end

                if (scan_reg < used_reg)
                begin
                    pend_valid_next = 1'b1;
                    pend_live_next  = live_reg[scan_slot];
                    scan_next       = scan_reg + CW'(1);
                end
                else
                begin
                    pend_valid_next = 1'b0;
                    if (!pend_valid_reg)
                    begin
                        res_next.status      = ST_OK;
                        res_next.slot_used   = '0;
                        res_next.range_start = acc_any_reg ? acc_a_reg : '0;
                        res_next.range_end   = acc_any_reg ? acc_b_reg : '0;
                        res_next.range_empty = !acc_any_reg;
                        res_next.holdable    = 1'b0;
                        state_next           = S_FINISH;
                    end
                end
            end

            S_FINISH:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (commit_en)
        begin
            ram_we                 = 1'b1;
            live_next[commit_slot] = 1'b1;
            if (commit_reuse)
            begin
                hole_next = hole_reg - CW'(1);
            end
            else
            begin
                used_next = used_reg + CW'(1);
            end
            wstart_next          = commit_ns;
            wend_next            = commit_ne;
            res_next.status      = ST_OK;
            res_next.slot_used   = SLOT_IDX_W'(commit_slot);
            res_next.range_start = commit_ns;
            res_next.range_end   = commit_ne;
            state_next           = S_FINISH;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            live_reg       <= '0;
            used_reg       <= '0;
            hole_reg       <= '0;
            wstart_reg     <= '0;
            wend_reg       <= '0;
            scan_reg       <= '0;
            pend_valid_reg <= 1'b0;
            acc_any_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            live_reg       <= live_next;
            used_reg       <= used_next;
            hole_reg       <= hole_next;
            wstart_reg     <= wstart_next;
            wend_reg       <= wend_next;
            scan_reg       <= scan_next;
            pend_valid_reg <= pend_valid_next;
            acc_any_reg    <= acc_any_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (item_xfer)
        begin
            cmd_reg <= item.cmd;
            s_reg   <= item.start_time;
            e_reg   <= end_sat;
            idx_reg <= item.slot_index;
        end
        ns_reg        <= ns_next;
        ne_reg        <= ne_next;
        pend_live_reg <= pend_live_next;
        acc_a_reg     <= acc_a_next;
        acc_b_reg     <= acc_b_next;
        res_reg       <= res_next;
        out_reg       <= out_next;
    end

endmodule

>>> sv/tecg_checker.sv
// Port-level checks for timer_event_coalescing_group, bound to the top level.
// Depends on tecg_pkg.
module tecg_checker
    import tecg_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_stall,
    input item_t   item,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result
);

    // one item at a time: a transfer closes the item channel next cycle
    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> item_stall)
        else $error("item channel open right after a transfer");

    // a stalled item stays offered and unchanged
    a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_stall) |=> (item_valid && $stable(item)))
        else $error("stalled item changed");

    // a new result only comes out of a busy sequencer
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_stall))
        else $error("result appeared with no item in work");

    // an empty delete range reads as zero
    a_empty_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.range_empty) |->
            (result.range_start == '0 && result.range_end == '0 &&
             result.status == ST_OK))
        else $error("empty range with nonzero bounds");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(result)))
        else $error("stalled result changed");

endmodule

bind timer_event_coalescing_group tecg_checker u_checker (.*);

>>> verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for timer_event_coalescing_group: directed cases, then random traffic.
// Depends on sv/tecg_pkg.sv and sv/timer_event_coalescing_group.sv.
module testbench;
    import tecg_pkg::*;

    localparam int N_SLOTS = SLOTS_DEFAULT;
    // cmd value 3 has no meaning; the block reports the window and changes nothing
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic [APB_ADDR_W-1:0] ADDR_MIN_OVERLAP = {REG_MIN_OVERLAP, 2'b00};
    // cycles with no transfer on any port before the run is declared hung
    localparam int STUCK_LIMIT = 1000;

    logic clk;
    logic rst_n;
    logic item_valid;
    logic item_stall;
    item_t item;
    logic result_valid;
    logic result_stall;
    result_t result;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    timer_event_coalescing_group u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // 4 ns clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // ------------------------------------------------------------------
    // Predicted group state: mirrors the slot table, the group window
    // and the two counters. used_cnt is the high-water mark of slots in
    // use, hole_cnt the dead slots below it; the group is empty when the
    // two are equal.
    // ------------------------------------------------------------------
    logic [TIME_W-1:0] grp_start [N_SLOTS];
    logic [TIME_W-1:0] grp_end [N_SLOTS];
    bit grp_live [N_SLOTS];
    logic [TIME_W-1:0] win_start;
    logic [TIME_W-1:0] win_end;
    int unsigned used_cnt;
    int unsigned hole_cnt;
    logic [OVERLAP_W-1:0] overlap_min;

    result_t pending_reports[$];
    int err_count;
    bit no_idle;      // when set, neither side inserts gaps or stalls
    int rx_hold;      // stall cycles still owed to the next result
    int stuck_cycles;

    // window end = start + slack, clamped at the top of the time range
    function automatic logic [TIME_W-1:0] window_close(logic [TIME_W-1:0] s,
                                                       logic [SLACK_W-1:0] d);
        logic [TIME_W:0] sum;
        sum = {1'b0, s} + {{(TIME_W + 1 - SLACK_W){1'b0}}, d};
        return sum[TIME_W] ? '1 : sum[TIME_W-1:0];
    endfunction

    // probe: does [s, e] overlap the stored group window by more than min_overlap
    function automatic bit window_holds(logic [TIME_W-1:0] s, logic [TIME_W-1:0] e);
        logic [TIME_W-1:0] lim;
        lim = {{(TIME_W - OVERLAP_W){1'b0}}, overlap_min};
        if (!(e > win_start && s < win_end))
            return 1'b0;
        if (s <= win_start)
            return (e - win_start) > lim;
        if (e <= win_end)
            return (e - s) > lim;
        return (win_end - s) > lim;
    endfunction

    // Applies one accepted transfer to the predicted state and returns the report.
    function automatic result_t coalesce_predict(item_t it);
        result_t r;
        logic [TIME_W-1:0] s, e, ns, ne, a, b;
        logic [TIME_W-1:0] lim;
        bit ok, reuse, any;
        int slot;
        int idx;
        s = it.start_time;
        e = window_close(it.start_time, it.slack);
        lim = {{(TIME_W - OVERLAP_W){1'b0}}, overlap_min};
        r = '0;
        r.status = ST_OK;
        r.range_start = win_start;
        r.range_end = win_end;
        case (it.cmd)
            CMD_ADD:
            begin
                ns = s;
                ne = e;
                ok = 1'b1;
                reuse = 1'b0;
                slot = 0;
                // non-empty group: the merged window has to stay wide enough
                if (used_cnt != hole_cnt)
                begin
                    if (s >= win_end || e <= win_start)
                        ok = 1'b0;
                    else
                    begin
                        if (ns <= win_start)
                            ns = win_start;
                        if (ne >= win_end)
                            ne = win_end;
                        if (ne - ns <= lim)
                            ok = 1'b0;
                    end
                    if (!ok)
                        r.status = ST_NO_OVERLAP;
                end
                if (ok)
                begin
                    // lowest dead slot below the high-water mark first
                    if (hole_cnt > 0)
                        for (int i = 0; i < N_SLOTS; i++)
                            if (i < used_cnt && !grp_live[i] && !reuse)
                            begin
                                slot = i;
                                reuse = 1'b1;
                            end
                    if (!reuse)
                    begin
                        if (used_cnt >= N_SLOTS)
                        begin
                            ok = 1'b0;
                            r.status = ST_FULL;
                        end
                        else
                            slot = used_cnt;
                    end
                end
                if (ok)
                begin
                    if (reuse)
                        hole_cnt--;
                    else
                        used_cnt++;
                    grp_start[slot] = s;
                    grp_end[slot] = e;
                    grp_live[slot] = 1'b1;
                    win_start = ns;
                    win_end = ne;
                    r.slot_used = SLOT_IDX_W'(slot);
                end
                r.range_start = win_start;
                r.range_end = win_end;
            end
            CMD_DELETE:
            begin
                idx = int'(it.slot_index);
                if (idx >= N_SLOTS || !grp_live[idx])
                    r.status = ST_NOT_LIVE;
                else
                begin
                    grp_live[idx] = 1'b0;
                    if (idx + 1 != used_cnt)
                        hole_cnt++;
                    else
                        used_cnt--;
                    // intersection of what is left; not adopted as the window
                    any = 1'b0;
                    a = '0;
                    b = '0;
                    for (int i = 0; i < N_SLOTS; i++)
                        if (i < used_cnt && grp_live[i])
                        begin
                            if (!any)
                            begin
                                a = grp_start[i];
                                b = grp_end[i];
                                any = 1'b1;
                            end
                            else
                            begin
                                if (a < grp_start[i])
                                    a = grp_start[i];
                                if (b > grp_end[i])
                                    b = grp_end[i];
                            end
                        end
                    r.range_start = a;
                    r.range_end = b;
                    r.range_empty = !any;
                end
            end
            CMD_PROBE:
                r.holdable = window_holds(s, e);
            default:
                ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Item side: optional gap, then hold the transfer until it is taken.
    // valid is only lowered when a gap follows, so back-to-back items
    // keep it high without a second assignment in the same step.
    // ------------------------------------------------------------------
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] st,
                             input logic [SLACK_W-1:0] sl, input logic [SLOT_IDX_W-1:0] idx);
        item_t it;
        int gap;
        it.cmd = cmd;
        it.start_time = st;
        it.slack = sl;
        it.slot_index = idx;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        pending_reports.push_back(coalesce_predict(it));
    endtask

    // Block must be quiet before a register write.
    task automatic wait_idle();
        item_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_min_overlap(input logic [OVERLAP_W-1:0] value);
        logic [APB_DATA_W-1:0] rd;
        wait_idle();
        // write: setup cycle, then access
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_MIN_OVERLAP;
        pwdata <= {{(APB_DATA_W - OVERLAP_W){1'b0}}, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        overlap_min = value;
        // read back
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rd = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (rd !== {{(APB_DATA_W - OVERLAP_W){1'b0}}, value})
        begin
            $error("min_overlap readback: expected %h, got %h", value, rd);
            err_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: compare each transfer against the oldest prediction,
    // then owe a random number of stall cycles to the next result.
    // ------------------------------------------------------------------
    task automatic check_report(input result_t got);
        result_t exp;
        if (pending_reports.size() == 0)
        begin
            $error("result transfer with nothing pending: %h", got);
            err_count++;
            return;
        end
        exp = pending_reports.pop_front();
        if (got.status !== exp.status)
        begin
            $error("status: expected %0d, got %0d", exp.status, got.status);
            err_count++;
        end
        if (got.slot_used !== exp.slot_used)
        begin
            $error("slot_used: expected %0d, got %0d", exp.slot_used, got.slot_used);
            err_count++;
        end
        if (got.range_start !== exp.range_start)
        begin
            $error("range_start: expected %h, got %h", exp.range_start, got.range_start);
            err_count++;
        end
        if (got.range_end !== exp.range_end)
        begin
            $error("range_end: expected %h, got %h", exp.range_end, got.range_end);
            err_count++;
        end
        if (got.range_empty !== exp.range_empty)
        begin
            $error("range_empty: expected %b, got %b", exp.range_empty, got.range_empty);
            err_count++;
        end
        if (got.holdable !== exp.holdable)
        begin
            $error("holdable: expected %b, got %b", exp.holdable, got.holdable);
            err_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            rx_hold = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                check_report(result);
                rx_hold = no_idle ? 0 : $urandom_range(0, 8);
            end
            else if (result_valid && rx_hold > 0)
                rx_hold--;
            result_stall <= (rx_hold > 0);
        end
    end

    // Watchdog: any transfer on either channel or the register port counts as progress.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
                (psel && penable && pready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("[timer_event_coalescing_group] ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // Fresh block: probe against the [0,0] window, the unused command,
    // deletes of slots that were never filled.
    task automatic test_reset_state();
        send_item(CMD_PROBE, 32'd0, 20'd100, 4'd0);
        send_item(CMD_UNUSED, 32'hFFFF_FFFF, 20'hF_FFFF, 4'd15);
        send_item(CMD_DELETE, 32'd0, 20'd0, 4'd15);
        send_item(CMD_DELETE, 32'hFFFF_FFFF, 20'hF_FFFF, 4'd0);
    endtask

    // Add to empty group, narrowing, overlap exactly min_overlap, disjoint on
    // either side, and probes in each overlap position.
    task automatic test_overlap_rules();
        send_item(CMD_ADD, 32'd1000, 20'd100, 4'd0);
        send_item(CMD_ADD, 32'd1050, 20'd100, 4'd0);
        send_item(CMD_ADD, 32'd1095, 20'd50, 4'd0);
        send_item(CMD_ADD, 32'd1100, 20'd10, 4'd0);
        send_item(CMD_ADD, 32'd900, 20'd100, 4'd0);
        send_item(CMD_PROBE, 32'd1000, 20'd1000, 4'd0);
        send_item(CMD_PROBE, 32'd1060, 20'd20, 4'd0);
        send_item(CMD_PROBE, 32'd1090, 20'd100, 4'd0);
        send_item(CMD_PROBE, 32'd1096, 20'd100, 4'd0);
    endtask

    // Hole creation and reuse, delete of the top slot, and a group that
    // goes empty while holes are still counted.
    task automatic test_delete_and_reuse();
        send_item(CMD_ADD, 32'd1040, 20'd60, 4'd0);
        send_item(CMD_DELETE, 32'd0, 20'd0, 4'd0);
        send_item(CMD_ADD, 32'd1055, 20'd45, 4'd0);
        send_item(CMD_DELETE, 32'd0, 20'd0, 4'd1);
        send_item(CMD_DELETE, 32'd0, 20'd0, 4'd2);
        send_item(CMD_DELETE, 32'd0, 20'd0, 4'd0);
    endtask

    // Window end clamps at the top of the time range.
    task automatic test_saturated_window();
        send_item(CMD_ADD, 32'hFFFF_FFF0, 20'hF_FFFF, 4'd0);
        send_item(CMD_PROBE, 32'hFFFF_FF00, 20'hF_FFFF, 4'd0);
        send_item(CMD_DELETE, 32'd0, 20'd0, 4'd0);
    endtask

    // ------------------------------------------------------------------
    // Random traffic in bursts. Each burst leans toward filling, churning
    // or draining the table; adds cluster around one base time so they
    // mostly merge, with stray adds, probes and raw noise mixed in.
    // ------------------------------------------------------------------
    task automatic test_random_traffic(input int n_items);
        int sent, burst_left, mode, pick, add_pct, del_pct, spread, slack_lo, r;
        logic [TIME_W-1:0] base, st;
        logic [SLACK_W-1:0] sl;
        logic [SLOT_IDX_W-1:0] idx;
        logic [CMD_W-1:0] cmd;
        int live_q[$];
        sent = 0;
        burst_left = 0;
        base = $urandom;
        spread = 0;
        slack_lo = 100;
        mode = 0;
        while (sent < n_items)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(10, 40);
                mode = $urandom_range(0, 2);
                no_idle = ($urandom_range(0, 3) == 0);
                // a new cluster only once the group has emptied
                if (used_cnt == hole_cnt)
                begin
                    r = $urandom_range(0, 9);
                    if (r == 0)
                        base = 32'hFFFF_FFFF - 32'($urandom_range(0, 3000));
                    else if (r == 1)
                        base = 32'($urandom_range(0, 3000));
                    else
                        base = $urandom;
                end
                spread = $urandom_range(0, 400);
                slack_lo = int'(overlap_min) + spread + $urandom_range(1, 2000);
            end
            case (mode)
                0:
                begin
                    add_pct = 85;
                    del_pct = 5;
                end
                1:
                begin
                    add_pct = 40;
                    del_pct = 35;
                end
                default:
                begin
                    add_pct = 15;
                    del_pct = 70;
                end
            endcase
            pick = $urandom_range(0, 99);
            idx = SLOT_IDX_W'($urandom_range(0, 15));
            if (pick < add_pct)
            begin
                cmd = CMD_ADD;
                if ($urandom_range(0, 9) != 0)
                begin
                    st = base + 32'($urandom_range(0, spread));
                    sl = SLACK_W'(slack_lo + $urandom_range(0, spread));
                end
                else
                begin
                    st = $urandom;
                    sl = SLACK_W'($urandom_range(0, 5000));
                end
            end
            else if (pick < add_pct + del_pct)
            begin
                cmd = CMD_DELETE;
                st = $urandom;
                sl = SLACK_W'($urandom);
                live_q.delete();
                for (int i = 0; i < N_SLOTS; i++)
                    if (grp_live[i])
                        live_q.push_back(i);
                if (live_q.size() != 0 && $urandom_range(0, 99) < 85)
                    idx = SLOT_IDX_W'(live_q[$urandom_range(0, live_q.size() - 1)]);
            end
            else if (pick < 95)
            begin
                cmd = CMD_PROBE;
                if ($urandom_range(0, 9) < 7)
                begin
                    st = win_start + 32'($urandom_range(0, 400)) - 32'd200;
                    sl = SLACK_W'($urandom_range(0, 2 * slack_lo));
                end
                else
                begin
                    st = $urandom;
                    sl = SLACK_W'($urandom);
                end
            end
            else
            begin
                // raw noise, the unused command included
                cmd = CMD_W'($urandom_range(0, 3));
                st = $urandom;
                sl = SLACK_W'($urandom);
            end
            send_item(cmd, st, sl, idx);
            sent++;
            burst_left--;
        end
        no_idle = 1'b0;
    endtask

    // Traffic under the reset setting, then at both extremes and a random value.
    task automatic test_min_overlap_sweep(input int n_per_setting);
        test_random_traffic(n_per_setting);
        set_min_overlap(16'd0);
        test_random_traffic(n_per_setting);
        set_min_overlap(16'hFFFF);
        test_random_traffic(n_per_setting);
        set_min_overlap(OVERLAP_W'($urandom_range(1, 2000)));
        test_random_traffic(n_per_setting);
        set_min_overlap(MIN_OVERLAP_RESET);
    endtask

    initial
    begin
        // all inputs known from time zero, reset held low before release
        rst_n <= 1'b0;
        item_valid <= 1'b0;
        item <= '0;
        result_stall <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        for (int i = 0; i < N_SLOTS; i++)
        begin
            grp_start[i] = '0;
            grp_end[i] = '0;
            grp_live[i] = 1'b0;
        end
        win_start = '0;
        win_end = '0;
        used_cnt = 0;
        hole_cnt = 0;
        overlap_min = MIN_OVERLAP_RESET;
        err_count = 0;
        no_idle = 1'b0;
        stuck_cycles = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_overlap_rules();
        test_delete_and_reuse();
        test_saturated_window();
        test_min_overlap_sweep(332);

        // drain, then let the block settle before the verdict
        wait_idle();
        repeat (25) @(posedge clk);
        if (err_count == 0)
            $display("[timer_event_coalescing_group] OK");
        else
            $display("[timer_event_coalescing_group] ERROR");
        $finish;
    end

endmodule
